// File: hdl/nmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nmb_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int CSR_WIDTH          = 16;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int NODE_WIDTH         = 16;

   localparam logic [CSR_WIDTH-1:0] SHORT_MIN_RESET = 16'd100;
   localparam logic [CSR_WIDTH-1:0] SHORT_MAX_RESET = 16'd2000;
   localparam logic [CSR_WIDTH-1:0] LONG_RESET      = 16'd4000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_MIN = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_MAX = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG      = 2'd2;

   localparam logic [1:0] DISP_UNINIT = 2'd0;
   localparam logic [1:0] DISP_SETUP  = 2'd1;
   localparam logic [1:0] DISP_NORMAL = 2'd2;

   typedef enum logic [1:0] {
      MODE_UNINIT  = 2'd0,
      MODE_PRE_CFG = 2'd1,
      MODE_CFG     = 2'd2,
      MODE_RUN     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_POLL     = 2'd0,
      OP_SET_NODE = 2'd1,
      OP_MODE_CMD = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      MSG_NONE = 3'd0,
      MSG_RQNN = 3'd1,
      MSG_ACK  = 3'd2,
      MSG_REL  = 3'd3,
      MSG_OK   = 3'd4
   } msg_kind_type;

   typedef struct packed {
      logic [1:0]            op;
      logic                  button_pressed;
      logic [NODE_WIDTH-1:0] new_node;
      logic [NODE_WIDTH-1:0] target_node;
      logic                  to_setup;
   } req_type;

   typedef struct packed {
      logic [2:0]            msg_kind;
      logic [NODE_WIDTH-1:0] msg_node;
      logic [1:0]            display_status;
      logic                  last;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/node_mode_button_fsm_unit.sv
// Node mode controller: push-button press timing and network mode commands.
// Input channel (req_): one item per poll tick or command; accepted on a
// rising edge with req_valid high and req_stall low. Each item gives one or
// two result items on the rsp_ channel, the final one flagged by last.
// Configuration (csr_): write short_min, short_max and long thresholds with
// csr_we, csr_index and csr_wdata while the block is idle.
// The first result of an item is written to the result queue on acceptance.
// Throughput: one item per cycle while items give a single result and the
// receiver does not stall; an item that gives two results holds the result
// port for both. Results wait in a four-entry queue; req_stall rises while
// over two are held; queue depth and the single result port set the rate.
// When the receiver stalls, the queue fills and input is stalled after three
// more items at most; nothing is dropped.
// Reset (synchronous): mode and return mode uninitialised, node numbers, press
// counter and was-pushed flag cleared, thresholds back to 100/2000/4000 ticks,
// result queue emptied.
`timescale 1ns / 1ps
`default_nettype none

module node_mode_button_fsm_unit #(
   parameter int COUNT_BITS = nmb_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire nmb_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output nmb_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [nmb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [nmb_pkg::CSR_WIDTH-1:0]        csr_wdata
);
   import nmb_pkg::*;

   localparam int CMP_W  = (COUNT_BITS > CSR_WIDTH) ? COUNT_BITS : CSR_WIDTH;
   localparam int DEPTH  = 4;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // thresholds
   logic [CSR_WIDTH-1:0] short_min_ff, short_max_ff, long_ff;

   // controller state
   mode_type              mode_ff, mode_in;
   mode_type              ret_ff, ret_in;
   logic [NODE_WIDTH-1:0] node_ff, node_in;
   logic [NODE_WIDTH-1:0] saved_ff, saved_in;
   logic [COUNT_BITS-1:0] press_ff, press_in;
   logic                  pushed_ff, pushed_in;

   // result queue
   rsp_type           fifo_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic                  req_accept, rsp_accept;
   op_type                op;
   logic [COUNT_BITS-1:0] t;
   logic [CMP_W-1:0]      t_cmp;
   logic                  is_short, over_long, at_long;
   logic                  hit_node;
   logic                  norm_short, norm_long;

   msg_kind_type          kind0, kind1;
   logic [NODE_WIDTH-1:0] node0, node1;
   logic                  two_msgs;
   logic [1:0]            disp;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > CNT_W'(DEPTH - 2);
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = fifo_ff[rd_ptr_ff];

   assign op        = op_type'(req_data.op);
   assign t         = (press_ff == '1) ? press_ff : press_ff + COUNT_BITS'(1);
   assign t_cmp     = CMP_W'(t);
   assign is_short  = (t_cmp > CMP_W'(short_min_ff)) && (t_cmp < CMP_W'(short_max_ff));
   assign over_long = t_cmp > CMP_W'(long_ff);
   assign at_long   = t_cmp >= CMP_W'(long_ff);
   assign hit_node  = req_data.target_node == node_ff;
   assign norm_short = pushed_ff && is_short;
   assign norm_long  = pushed_ff && at_long;

   // next state
   always_comb begin
      mode_in   = mode_ff;
      ret_in    = ret_ff;
      node_in   = node_ff;
      saved_in  = saved_ff;
      press_in  = press_ff;
      pushed_in = pushed_ff;
      unique case (op)
         OP_POLL: begin
            unique case (mode_ff)
               MODE_UNINIT: begin
                  if (!req_data.button_pressed) begin
                     press_in = '0;
                  end else begin
                     press_in = t;
                     if (over_long) begin
                        mode_in = MODE_PRE_CFG;
                        ret_in  = MODE_UNINIT;
                     end
                  end
               end
               MODE_PRE_CFG: begin
                  if (!req_data.button_pressed) begin
                     mode_in = MODE_CFG;
                     ret_in  = MODE_UNINIT;
                  end
                  press_in = '0;
               end
               MODE_CFG: begin
                  if (!req_data.button_pressed) begin
                     if (is_short) begin
                        mode_in = ret_ff;
                        if (ret_ff == MODE_RUN) begin
                           node_in = saved_ff;
                        end
                     end
                     if (over_long) begin
                        mode_in = MODE_UNINIT;
                     end
                     press_in  = '0;
                     pushed_in = 1'b0;
                  end else begin
                     pushed_in = 1'b1;
                     press_in  = t;
                  end
               end
               MODE_RUN: begin
                  if (!req_data.button_pressed) begin
                     if (norm_short || norm_long) begin
                        node_in = '0;
                        ret_in  = MODE_RUN;
                        // a press both short and long ends with node 0 saved
                        saved_in = norm_short ? '0 : node_ff;
                        if (!norm_short) saved_in = node_ff;
                        if (norm_short && !norm_long) saved_in = node_ff;
                        mode_in = norm_long ? MODE_UNINIT : MODE_CFG;
                     end
                     press_in  = '0;
                     pushed_in = 1'b0;
                  end else begin
                     pushed_in = 1'b1;
                     press_in  = t;
                  end
               end
               default: ;
            endcase
         end
         OP_SET_NODE: begin
            if (mode_ff == MODE_CFG) begin
               node_in = req_data.new_node;
               mode_in = MODE_RUN;
            end
         end
         OP_MODE_CMD: begin
            if (mode_ff != MODE_CFG && hit_node) begin
               saved_in = node_ff;
               if (mode_ff == MODE_RUN) begin
                  node_in = '0;
                  mode_in = req_data.to_setup ? MODE_CFG : MODE_UNINIT;
                  ret_in  = MODE_RUN;
               end
            end
         end
         default: ;
      endcase
   end

   // messages
   always_comb begin
      kind0    = MSG_NONE;
      node0    = '0;
      kind1    = MSG_NONE;
      node1    = '0;
      two_msgs = 1'b0;
      unique case (op)
         OP_POLL: begin
            if (!req_data.button_pressed) begin
               unique case (mode_ff)
                  MODE_PRE_CFG: begin
                     kind0 = MSG_RQNN;
                     node0 = node_ff;
                  end
                  MODE_CFG: begin
                     if (is_short && ret_ff == MODE_RUN) begin
                        kind0 = MSG_ACK;
                        node0 = saved_ff;
                     end
                  end
                  MODE_RUN: begin
                     if (norm_short && norm_long) begin
                        kind0    = MSG_RQNN;
                        node0    = node_ff;
                        kind1    = MSG_REL;
                        node1    = '0;
                        two_msgs = 1'b1;
                     end else if (norm_short) begin
                        kind0 = MSG_RQNN;
                        node0 = node_ff;
                     end else if (norm_long) begin
                        kind0 = MSG_REL;
                        node0 = node_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_SET_NODE: begin
            if (mode_ff == MODE_CFG) begin
               kind0 = MSG_ACK;
               node0 = req_data.new_node;
            end
         end
         OP_MODE_CMD: begin
            if (mode_ff == MODE_RUN && hit_node) begin
               kind0    = req_data.to_setup ? MSG_RQNN : MSG_REL;
               node0    = node_ff;
               kind1    = MSG_OK;
               node1    = node_ff;
               two_msgs = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (mode_in)
         MODE_UNINIT: disp = DISP_UNINIT;
         MODE_RUN:    disp = DISP_NORMAL;
         default:     disp = DISP_SETUP;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (req_accept) count_in = count_in + (two_msgs ? CNT_W'(2) : CNT_W'(1));
      if (rsp_accept) count_in = count_in - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_min_ff <= SHORT_MIN_RESET;
         short_max_ff <= SHORT_MAX_RESET;
         long_ff      <= LONG_RESET;
         mode_ff      <= MODE_UNINIT;
         ret_ff       <= MODE_UNINIT;
         node_ff      <= '0;
         saved_ff     <= '0;
         press_ff     <= '0;
         pushed_ff    <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SHORT_MIN: short_min_ff <= csr_wdata;
               CSR_SHORT_MAX: short_max_ff <= csr_wdata;
               CSR_LONG:      long_ff      <= csr_wdata;
               default: ;
            endcase
         end
         if (req_accept) begin
            mode_ff   <= mode_in;
            ret_ff    <= ret_in;
            node_ff   <= node_in;
            saved_ff  <= saved_in;
            press_ff  <= press_in;
            pushed_ff <= pushed_in;
            wr_ptr_ff <= two_msgs ? wr_ptr_ff + PTR_W'(2) : wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_accept) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         fifo_ff[wr_ptr_ff] <= '{msg_kind: kind0, msg_node: node0,
                                 display_status: disp, last: !two_msgs};
         if (two_msgs) begin
            fifo_ff[wr_ptr_ff + PTR_W'(1)] <= '{msg_kind: kind1, msg_node: node1,
                                                display_status: disp, last: 1'b1};
         end
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue over-full");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted item left no result");

   a_first_carries_msg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.msg_kind != MSG_NONE))
      else $error("non-final result without message");

   a_pair_disp: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !rsp_data.last) |=>
         (rsp_valid && rsp_data.display_status == $past(rsp_data.display_status)))
      else $error("second result missing or display mismatch");
`endif

endmodule

`default_nettype wire
